// File: design/cfnu_pkg.sv
// ============================================================================
// Candle flicker node update - shared package
// Types, constants and codes used by the node update datapath.
// ============================================================================
`default_nettype none

package cfnu_pkg;

    // Node state store geometry.
    localparam int NODES       = 1024;
    localparam int NODE_ADDR_W = $clog2(NODES);
    localparam int NODE_IDX_W  = 10;
    localparam int BYTE_W      = 8;
    localparam int GREEN_W     = 7;
    localparam int CALM_W      = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    // Opcodes of an input beat.
    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_FLAME_AGILITY    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIND_CALMNESS    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIND_VARIABILITY = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIND_BASELINE    = 2'd3;

    typedef struct packed {
        logic                  opcode;
        logic [NODE_IDX_W-1:0] node_index;
        logic [BYTE_W-1:0]     rand_gust_red;
        logic [BYTE_W-1:0]     rand_wind_red;
        logic [BYTE_W-1:0]     rand_knock_red;
        logic [BYTE_W-1:0]     rand_flame_red;
        logic [BYTE_W-1:0]     rand_gust_green;
        logic [BYTE_W-1:0]     rand_wind_green;
        logic [BYTE_W-1:0]     rand_knock_green;
        logic [BYTE_W-1:0]     rand_flame_green;
    } in_beat_t;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] out_node;
        logic [BYTE_W-1:0]     red;
        logic [GREEN_W-1:0]    green;
    } out_beat_t;

    // One 40-bit entry of the node state store.
    typedef struct packed {
        logic [BYTE_W-1:0] flame_r;
        logic [BYTE_W-1:0] filt_r;
        logic [BYTE_W-1:0] flame_g;
        logic [BYTE_W-1:0] filt_g;
        logic [BYTE_W-1:0] wind;
    } node_state_t;

    localparam int NODE_STATE_W = $bits(node_state_t);

    typedef struct packed {
        logic [BYTE_W-1:0] flame_agility;
        logic [CALM_W-1:0] wind_calmness;
        logic [BYTE_W-1:0] wind_variability;
        logic [BYTE_W-1:0] wind_baseline;
    } cfg_t;

    // State that one color pass works on.
    typedef struct packed {
        logic [BYTE_W-1:0] flame;
        logic [BYTE_W-1:0] filt;
        logic [BYTE_W-1:0] wind;
    } pass_state_t;

    // Random bytes consumed by one color pass.
    typedef struct packed {
        logic [BYTE_W-1:0] gust;
        logic [BYTE_W-1:0] new_wind;
        logic [BYTE_W-1:0] knock;
        logic [BYTE_W-1:0] new_flame;
    } pass_rand_t;

endpackage : cfnu_pkg

`default_nettype wire

// File: design/cfnu_state_ram.sv
// ============================================================================
// Candle flicker node update - node state memory
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ============================================================================
`default_nettype none

module cfnu_state_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 40,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule : cfnu_state_ram

`default_nettype wire

// File: design/cfnu_flicker_pass.sv
// ============================================================================
// Candle flicker node update - flicker pass
// One color pass: wind gust, wind decay, flame rise, knockdown and the
// constant-rate filter on the flame height.
// ============================================================================
`default_nettype none

module cfnu_flicker_pass (
    input  wire cfnu_pkg::cfg_t        cfg,
    input  wire cfnu_pkg::pass_state_t cur,
    input  wire cfnu_pkg::pass_rand_t  rnd,
    output cfnu_pkg::pass_state_t      nxt
);

    logic [cfnu_pkg::BYTE_W-1:0] wind_gust;
    logic [cfnu_pkg::BYTE_W-1:0] wind_decay;
    logic [cfnu_pkg::BYTE_W-1:0] wind_shifted;
    logic [cfnu_pkg::BYTE_W-1:0] flame_rise;
    logic [cfnu_pkg::BYTE_W-1:0] flame_final;
    logic [cfnu_pkg::BYTE_W-1:0] filt_final;

    always_comb begin
        wind_gust    = (rnd.gust < cfg.wind_variability) ? rnd.new_wind : cur.wind;
        wind_decay   = (wind_gust > cfg.wind_baseline) ? wind_gust - 8'd1 : wind_gust;
        flame_rise   = (cur.flame < cfnu_pkg::BYTE_MAX) ? cur.flame + 8'd1 : cur.flame;
        wind_shifted = wind_decay >> cfg.wind_calmness;
        flame_final  = (rnd.knock < wind_shifted) ? rnd.new_flame : flame_rise;

        // The filter moves by a fixed step and never wraps past either end.
        filt_final = cur.filt;
        if (flame_final > cur.filt) begin
            if (cur.filt < (cfnu_pkg::BYTE_MAX - cfg.flame_agility)) begin
                filt_final = cur.filt + cfg.flame_agility;
            end
        end else begin
            if (cur.filt > cfg.flame_agility) begin
                filt_final = cur.filt - cfg.flame_agility;
            end
        end

        nxt.flame = flame_final;
        nxt.filt  = filt_final;
        nxt.wind  = wind_decay;
    end

endmodule : cfnu_flicker_pass

`default_nettype wire

// File: design/candle_flicker_node_update.sv
// ============================================================================
// Candle flicker node update - top level
// Per-node candle flicker state update with an on-chip node state memory.
// ============================================================================
// The block keeps five bytes of flicker state for each of 1024 LED nodes in a
// synchronous memory and handles one input beat at a time. An init beat loads
// a node's state from its random bytes; an update beat reads the node's state,
// runs the red pass and then the green pass through one shared flicker unit,
// applies the green clamps and writes the entry back. Every input beat yields
// exactly one output beat with the node index, red and green intensity. The
// memory read is issued on the accepting edge. The red pass runs in the next
// cycle and the green pass in the cycle after that. The write-back and the
// load of the output register happen on the edge that leaves the green pass,
// which waits there while the previous result is still waiting on m_ready.
// The block then returns to idle, ready for the next beat; it takes no new
// beat before it is through with the last one. The memory has no reset; a
// node must see an init beat before its first update. The node index is used
// modulo the node count and is returned unchanged.
// Configuration must be written only while the block is idle.
// ============================================================================
`default_nettype none

module candle_flicker_node_update (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [cfnu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [cfnu_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire cfnu_pkg::in_beat_t                  s_payload,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output cfnu_pkg::out_beat_t                      m_payload
);

    // Sequencer states: waiting for a beat, red pass, green pass.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RED   = 2'd1;
    localparam logic [1:0] ST_GREEN = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    cfnu_pkg::cfg_t        cfg_reg;
    cfnu_pkg::in_beat_t    item_reg;
    cfnu_pkg::node_state_t work_reg;
    cfnu_pkg::node_state_t work_next;
    logic                  m_valid_reg;
    cfnu_pkg::out_beat_t   m_payload_reg;

    logic                                    s_accept;
    logic                                    out_free;
    logic                                    finish;
    logic [cfnu_pkg::NODE_STATE_W-1:0]       rd_data;
    cfnu_pkg::node_state_t                   mem_entry;
    cfnu_pkg::node_state_t                   wb_entry;
    cfnu_pkg::pass_state_t                   pass_cur;
    cfnu_pkg::pass_rand_t                    pass_rnd;
    cfnu_pkg::pass_state_t                   pass_nxt;
    logic [cfnu_pkg::NODE_ADDR_W-1:0]        item_addr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == ST_GREEN) && out_free;
    assign mem_entry = cfnu_pkg::node_state_t'(rd_data);
    assign item_addr = item_reg.node_index[cfnu_pkg::NODE_ADDR_W-1:0];
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Configuration registers. The index is exactly as wide as the register
    // list, so every write lands on a register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flame_agility    <= 8'd2;
            cfg_reg.wind_calmness    <= 4'd2;
            cfg_reg.wind_variability <= 8'd5;
            cfg_reg.wind_baseline    <= 8'd30;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                cfnu_pkg::CFG_FLAME_AGILITY: begin
                    cfg_reg.flame_agility <= cfg_wdata;
                end
                cfnu_pkg::CFG_WIND_CALMNESS: begin
                    cfg_reg.wind_calmness <= cfg_wdata[cfnu_pkg::CALM_W-1:0];
                end
                cfnu_pkg::CFG_WIND_VARIABILITY: begin
                    cfg_reg.wind_variability <= cfg_wdata;
                end
                cfnu_pkg::CFG_WIND_BASELINE: begin
                    cfg_reg.wind_baseline <= cfg_wdata;
                end
            endcase
        end
    end

    // The memory read is issued on the accepting edge, so its data is ready
    // in the red pass cycle. The write-back lands on the edge that leaves the
    // green pass, before the next beat can be accepted, so a read never sees
    // a stale entry and no forwarding is needed.
    cfnu_state_ram #(
        .DEPTH (cfnu_pkg::NODES),
        .WIDTH (cfnu_pkg::NODE_STATE_W)
    ) u_state_ram (
        .aclk        (aclk),
        .wr_en       (finish),
        .wr_addr     (item_addr),
        .wr_data     (wb_entry),
        .rd_en       (s_accept),
        .rd_addr     (s_payload.node_index[cfnu_pkg::NODE_ADDR_W-1:0]),
        .rd_data_reg (rd_data)
    );

    // The single flicker unit serves the red pass first and the green pass
    // next; the green pass starts from the wind byte the red pass left in work_reg.
    always_comb begin
        if (state_reg == ST_GREEN) begin
            pass_cur.flame     = work_reg.flame_g;
            pass_cur.filt      = work_reg.filt_g;
            pass_cur.wind      = work_reg.wind;
            pass_rnd.gust      = item_reg.rand_gust_green;
            pass_rnd.new_wind  = item_reg.rand_wind_green;
            pass_rnd.knock     = item_reg.rand_knock_green;
            pass_rnd.new_flame = item_reg.rand_flame_green;
        end else begin
            pass_cur.flame     = mem_entry.flame_r;
            pass_cur.filt      = mem_entry.filt_r;
            pass_cur.wind      = mem_entry.wind;
            pass_rnd.gust      = item_reg.rand_gust_red;
            pass_rnd.new_wind  = item_reg.rand_wind_red;
            pass_rnd.knock     = item_reg.rand_knock_red;
            pass_rnd.new_flame = item_reg.rand_flame_red;
        end
    end

    cfnu_flicker_pass u_flicker_pass (
        .cfg (cfg_reg),
        .cur (pass_cur),
        .rnd (pass_rnd),
        .nxt (pass_nxt)
    );

    // Red pass result joins the untouched green bytes of the entry.
    always_comb begin
        work_next         = mem_entry;
        work_next.flame_r = pass_nxt.flame;
        work_next.filt_r  = pass_nxt.filt;
        work_next.wind    = pass_nxt.wind;
    end

    // Entry written back at the end of the green pass. An init beat stores
    // its random bytes as they are. An update clamps the green filtered flame
    // to the red one when it is higher, and also whenever the green flame
    // itself is above the red flame.
    always_comb begin
        if (item_reg.opcode == cfnu_pkg::OP_INIT) begin
            wb_entry.flame_r = item_reg.rand_gust_red;
            wb_entry.filt_r  = item_reg.rand_wind_red;
            wb_entry.flame_g = item_reg.rand_knock_red;
            wb_entry.filt_g  = item_reg.rand_flame_red;
            wb_entry.wind    = item_reg.rand_gust_green;
        end else begin
            wb_entry.flame_r = work_reg.flame_r;
            wb_entry.filt_r  = work_reg.filt_r;
            wb_entry.flame_g = pass_nxt.flame;
            wb_entry.wind    = pass_nxt.wind;
            if ((pass_nxt.filt > work_reg.filt_r) || (pass_nxt.flame > work_reg.flame_r)) begin
                wb_entry.filt_g = work_reg.filt_r;
            end else begin
                wb_entry.filt_g = pass_nxt.filt;
            end
        end
    end

    // Sequencer. The green pass waits there while the output register still
    // holds an untaken beat.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                state_next = ST_GREEN;
            end
            ST_GREEN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_payload;
        end
        if (state_reg == ST_RED) begin
            work_reg <= work_next;
        end
        if (finish) begin
            m_payload_reg.out_node <= item_reg.node_index;
            m_payload_reg.red      <= wb_entry.filt_r;
            m_payload_reg.green    <= wb_entry.filt_g[cfnu_pkg::BYTE_W-1:1];
        end
    end

endmodule : candle_flicker_node_update

`default_nettype wire

// File: design/cfnu_checker.sv
// ============================================================================
// Candle flicker node update - port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ============================================================================
`default_nettype none

module cfnu_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire cfnu_pkg::out_beat_t m_payload
);

    // A waiting result beat stays offered.
    a_m_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before it was taken");

    // A waiting result beat keeps its payload.
    a_m_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_payload))
        else $error("result payload changed while stalled");

    // The block takes one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##3 m_valid)
        else $error("no result beat after an accepted item");

endmodule : cfnu_checker

bind candle_flicker_node_update cfnu_checker u_cfnu_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Candle flicker node update - testbench
// Drives init and update beats with random stalls on both channels and checks
// every output color against a cycle-free model of the node state store.
// ============================================================================

module tb_top;

    import cfnu_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block.
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;

    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_payload;

    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_payload;

    candle_flicker_node_update dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The run is ended here if the block stops moving beats.
    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the block: its own copy of the registers and the node store.
    // A node is marked loaded once an init beat for it has been accepted, and
    // the stimulus never sends an update to a node that is not loaded, since
    // the hardware memory holds garbage until then.
    // ------------------------------------------------------------------------
    cfg_t        cfg_shadow;
    node_state_t node_mem    [NODES];
    bit          node_loaded [NODES];

    // Colors still owed by the block, oldest first.
    out_beat_t   pending_colors[$];

    int          error_count;

    // When set, neither side inserts idle cycles.
    bit          no_stall;

    // One flicker pass of one color: gust, wind decay, flame rise, knockdown
    // by the wind and the constant-rate filter on the flame height.
    function automatic void run_pass(inout pass_state_t ps, input pass_rand_t rnd);
        if (rnd.gust < cfg_shadow.wind_variability) begin
            ps.wind = rnd.new_wind;
        end
        if (ps.wind > cfg_shadow.wind_baseline) begin
            ps.wind = ps.wind - 8'd1;
        end
        if (ps.flame != BYTE_MAX) begin
            ps.flame = ps.flame + 8'd1;
        end
        // A calmness above 8 shifts the whole wind byte away: no knockdown.
        if (rnd.knock < (ps.wind >> cfg_shadow.wind_calmness)) begin
            ps.flame = rnd.new_flame;
        end
        if (ps.flame > ps.filt) begin
            if (int'(ps.filt) < int'(BYTE_MAX) - int'(cfg_shadow.flame_agility)) begin
                ps.filt = ps.filt + cfg_shadow.flame_agility;
            end
        end else if (ps.filt > cfg_shadow.flame_agility) begin
            ps.filt = ps.filt - cfg_shadow.flame_agility;
        end
    endfunction

    // Applies one accepted beat to the model store and returns the color the
    // block has to emit for it.
    function automatic out_beat_t predict_node_color(input in_beat_t beat);
        node_state_t ns;
        pass_state_t red_ps;
        pass_state_t grn_ps;
        pass_rand_t  red_rnd;
        pass_rand_t  grn_rnd;
        out_beat_t   color;
        int unsigned slot;

        slot = beat.node_index % NODES;
        if (beat.opcode == OP_INIT) begin
            // An init beat loads the entry and reports it without any clamp.
            ns.flame_r = beat.rand_gust_red;
            ns.filt_r  = beat.rand_wind_red;
            ns.flame_g = beat.rand_knock_red;
            ns.filt_g  = beat.rand_flame_red;
            ns.wind    = beat.rand_gust_green;
        end else begin
            ns = node_mem[slot];
            red_ps.flame      = ns.flame_r;
            red_ps.filt       = ns.filt_r;
            red_ps.wind       = ns.wind;
            red_rnd.gust      = beat.rand_gust_red;
            red_rnd.new_wind  = beat.rand_wind_red;
            red_rnd.knock     = beat.rand_knock_red;
            red_rnd.new_flame = beat.rand_flame_red;
            run_pass(red_ps, red_rnd);

            // The green pass starts from the wind that the red pass left.
            grn_ps.flame      = ns.flame_g;
            grn_ps.filt       = ns.filt_g;
            grn_ps.wind       = red_ps.wind;
            grn_rnd.gust      = beat.rand_gust_green;
            grn_rnd.new_wind  = beat.rand_wind_green;
            grn_rnd.knock     = beat.rand_knock_green;
            grn_rnd.new_flame = beat.rand_flame_green;
            run_pass(grn_ps, grn_rnd);

            // Usual clamp of green filtered to red filtered, then the second
            // clamp keyed on the raw flame heights.
            if (grn_ps.filt > red_ps.filt) begin
                grn_ps.filt = red_ps.filt;
            end
            if (grn_ps.flame > red_ps.flame) begin
                grn_ps.filt = red_ps.filt;
            end

            ns.flame_r = red_ps.flame;
            ns.filt_r  = red_ps.filt;
            ns.flame_g = grn_ps.flame;
            ns.filt_g  = grn_ps.filt;
            ns.wind    = grn_ps.wind;
        end
        node_mem[slot]    = ns;
        node_loaded[slot] = 1'b1;

        color.out_node = beat.node_index;
        color.red      = ns.filt_r;
        color.green    = ns.filt_g[BYTE_W-1:1];
        return color;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: m_ready is moved at the falling edge and each output beat
    // is checked at the rising edge where it is taken.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, wanted %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= no_stall || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge aclk) begin : check_colors
        out_beat_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_colors.size() == 0) begin
                report_mismatch("unrequested beat, node", m_payload.out_node, -1);
            end else begin
                want = pending_colors.pop_front();
                if (m_payload.out_node !== want.out_node) begin
                    report_mismatch("out_node", m_payload.out_node, want.out_node);
                end
                if (m_payload.red !== want.red) begin
                    report_mismatch("red", m_payload.red, want.red);
                end
                if (m_payload.green !== want.green) begin
                    report_mismatch("green", m_payload.green, want.green);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Every task here starts and ends at a falling edge. After an
    // accepted beat s_valid stays high until the next call decides what to do
    // with it, so that it is assigned once per falling edge.
    // ------------------------------------------------------------------------
    task automatic send_beat(input in_beat_t beat);
        while (!no_stall && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_colors.insert(pending_colors.size(), predict_node_color(beat));
        @(negedge aclk);
    endtask

    // Stops sending, waits until every owed color is out and then lets the block go quiet.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_colors.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_FLAME_AGILITY:    cfg_shadow.flame_agility    = data;
            CFG_WIND_CALMNESS:    cfg_shadow.wind_calmness    = data[CALM_W-1:0];
            CFG_WIND_VARIABILITY: cfg_shadow.wind_variability = data;
            CFG_WIND_BASELINE:    cfg_shadow.wind_baseline    = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Writes all four registers once the block is idle. The calmness register
    // only keeps its low nibble, so the upper bits of its data are random.
    task automatic apply_settings(input logic [7:0] agility, input logic [3:0] calmness,
                                  input logic [7:0] variability, input logic [7:0] baseline);
        drain_pipeline();
        write_reg(CFG_FLAME_AGILITY, agility);
        write_reg(CFG_WIND_CALMNESS, {4'($urandom_range(15)), calmness});
        write_reg(CFG_WIND_VARIABILITY, variability);
        write_reg(CFG_WIND_BASELINE, baseline);
    endtask

    function automatic in_beat_t init_beat(input logic [9:0] idx, input logic [7:0] fr,
                                           input logic [7:0] pr, input logic [7:0] fg,
                                           input logic [7:0] pg, input logic [7:0] wind);
        in_beat_t b;
        b = '0;
        b.opcode          = OP_INIT;
        b.node_index      = idx;
        b.rand_gust_red   = fr;
        b.rand_wind_red   = pr;
        b.rand_knock_red  = fg;
        b.rand_flame_red  = pg;
        b.rand_gust_green = wind;
        return b;
    endfunction

    function automatic in_beat_t update_beat(input logic [9:0] idx,
                                             input logic [31:0] red_bytes,
                                             input logic [31:0] green_bytes);
        in_beat_t b;
        b.opcode     = OP_UPDATE;
        b.node_index = idx;
        {b.rand_gust_red, b.rand_wind_red, b.rand_knock_red, b.rand_flame_red} = red_bytes;
        {b.rand_gust_green, b.rand_wind_green, b.rand_knock_green,
         b.rand_flame_green} = green_bytes;
        return b;
    endfunction

    // Gust and knockdown tests only fire on small bytes, so those bytes are
    // drawn from the low end about a third of the time.
    function automatic logic [7:0] test_byte();
        if ($urandom_range(99) < 35) begin
            return 8'($urandom_range(15));
        end
        return 8'($urandom_range(255));
    endfunction

    // Random beat on a node of the window [lo, hi]. A node that has not been
    // loaded always gets an init beat first; loaded nodes mostly get updates,
    // so the flicker state runs through long sequences.
    function automatic in_beat_t random_flicker_beat(input int unsigned lo,
                                                      input int unsigned hi);
        in_beat_t b;
        b.node_index       = 10'($urandom_range(hi, lo));
        b.rand_gust_red    = test_byte();
        b.rand_wind_red    = 8'($urandom_range(255));
        b.rand_knock_red   = test_byte();
        b.rand_flame_red   = 8'($urandom_range(255));
        b.rand_gust_green  = test_byte();
        b.rand_wind_green  = 8'($urandom_range(255));
        b.rand_knock_green = test_byte();
        b.rand_flame_green = 8'($urandom_range(255));
        if (!node_loaded[b.node_index % NODES] || $urandom_range(99) < 12) begin
            b.opcode = OP_INIT;
            // Inits also carry full-range state bytes in the test slots.
            b.rand_gust_red   = 8'($urandom_range(255));
            b.rand_knock_red  = 8'($urandom_range(255));
            b.rand_gust_green = 8'($urandom_range(255));
        end else begin
            b.opcode = OP_UPDATE;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Hand-picked beats under the reset values of the registers: field
    // extremes, saturation of the filter, gust and knockdown, the unclamped
    // init result and the clamp on raw flame heights.
    task automatic test_directed_cases();
        // All-zero node, then a calm update: the flame only rises by one.
        send_beat(init_beat(10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(update_beat(10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // All-ones node on the top index, then every random byte at zero:
        // gusts fire with a zero wind, the flame is already at its top.
        send_beat(init_beat(10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_beat(update_beat(10'd1023, 32'h0000_0000, 32'h0000_0000));
        // Strong gusts with knockdowns on both colors, first to zero, then to 255 on red and 128 on green.
        send_beat(update_beat(10'd1023, 32'h00FF_0000, 32'h00FF_0000));
        send_beat(update_beat(10'd1023, 32'h00FF_00FF, 32'h00FF_0080));
        // Init result is reported as loaded, green filtered above red.
        send_beat(init_beat(10'd5, 8'd0, 8'd0, 8'd0, 8'hFF, 8'd0));
        // Green flame above red flame forces green filtered to red filtered
        // even though green filtered is the lower one.
        send_beat(init_beat(10'd6, 8'd10, 8'd100, 8'd200, 8'd20, 8'd0));
        send_beat(update_beat(10'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Filter at its upper limit: 253 stays, 252 steps up to 254 and is clamped to 253.
        send_beat(init_beat(10'd7, 8'hFF, 8'd253, 8'hFF, 8'd252, 8'd0));
        send_beat(update_beat(10'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Filter at its lower limit: a value equal to the step stays put.
        send_beat(init_beat(10'd8, 8'd0, 8'd2, 8'd0, 8'd3, 8'd0));
        send_beat(update_beat(10'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // High wind decays toward the baseline across both passes.
        send_beat(init_beat(10'h2AA, 8'd50, 8'd60, 8'd40, 8'd30, 8'd200));
        send_beat(update_beat(10'h2AA, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(init_beat(10'h155, 8'd128, 8'd128, 8'd128, 8'd128, 8'd31));
        send_beat(update_beat(10'h155, 32'h04AA_0155, 32'h0555_0000));
    endtask

    // Several register settings, the extremes among them, each followed by
    // random beats on a small window of nodes.
    task automatic test_register_sweep();
        logic [7:0] agility  [6];
        logic [3:0] calmness [6];
        logic [7:0] variab   [6];
        logic [7:0] baseline [6];
        int unsigned lo;

        agility  = '{8'd0,   8'd255, 8'd1,   8'd128, 8'd7,   8'($urandom_range(255))};
        calmness = '{4'd0,   4'd15,  4'd8,   4'd0,   4'd3,   4'($urandom_range(15))};
        variab   = '{8'd0,   8'd255, 8'd128, 8'd255, 8'd40,  8'($urandom_range(255))};
        baseline = '{8'd0,   8'd255, 8'd0,   8'd30,  8'd100, 8'($urandom_range(255))};
        for (int s = 0; s < 6; s++) begin
            apply_settings(agility[s], calmness[s], variab[s], baseline[s]);
            lo = $urandom_range(NODES - 8);
            repeat (40) send_beat(random_flicker_beat(lo, lo + 7));
        end
    endtask

    // The bulk of the run: one random setting, then chunks of random beats on
    // windows of varying width. One chunk runs with no stalls on either side,
    // and once the sender holds off until every owed color has come out.
    task automatic test_random_flicker();
        int unsigned lo;
        int unsigned span;

        apply_settings(8'($urandom_range(8)), 4'($urandom_range(4)),
                       8'($urandom_range(64)), 8'($urandom_range(255)));
        for (int chunk = 0; chunk < 5; chunk++) begin
            no_stall = (chunk == 1);
            if (chunk == 3) begin
                span = NODES;
                lo   = 0;
            end else begin
                span = $urandom_range(16, 2);
                lo   = $urandom_range(NODES - span);
            end
            repeat (100) send_beat(random_flicker_beat(lo, lo + span - 1));
            if (chunk == 2) begin
                drain_pipeline();
            end
        end
        no_stall = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_payload   = '0;
        m_ready     = 1'b0;
        no_stall    = 1'b0;
        error_count = 0;

        cfg_shadow.flame_agility    = 8'd2;
        cfg_shadow.wind_calmness    = 4'd2;
        cfg_shadow.wind_variability = 8'd5;
        cfg_shadow.wind_baseline    = 8'd30;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_register_sweep();
        test_random_flicker();

        drain_pipeline();
        repeat (20) @(negedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
